>>> rtl/hdrtm_pkg.sv
`timescale 1ns / 1ps

package hdrtm_pkg;

	// Field and datapath widths
	localparam int HalfW     = 16;
	localparam int ScaleW    = 20;
	localparam int ProdW     = 31;
	localparam int LinW      = 33;
	localparam int CodeW     = 8;
	localparam int ChanCnt   = 3;
	localparam int CfgIdxW   = 2;
	localparam int SrchSteps = CodeW;
	// two linearize stages, then one stage per search step
	localparam int StageCnt  = 2 + SrchSteps;
	localparam int TabDepth  = 2 ** CodeW;

	// Half-precision exponent of infinity and NaN
	localparam logic [4:0] ExpMax = 5'h1F;

	// Configuration register indexes
	localparam logic [CfgIdxW-1:0] CfgWhiteScale = CfgIdxW'(0);
	localparam logic [CfgIdxW-1:0] CfgByteOrder  = CfgIdxW'(1);

	// Reset values and fixed codes
	localparam logic [ScaleW-1:0] WhiteScaleRst = ScaleW'(65536);
	localparam logic [CodeW-1:0]  AlphaCode     = 8'hFF;
	localparam logic [LinW-1:0]   OneLin        = 33'h1_0000_0000;

	// Last code whose threshold sits on the linear segment
	localparam int LinLastCode = 10;

	// Input pixel transaction
	typedef struct packed {
		logic [HalfW-1:0] red_half;
		logic [HalfW-1:0] green_half;
		logic [HalfW-1:0] blue_half;
		logic             last_pixel;
	} pix_t;

	// Output pixel transaction
	typedef struct packed {
		logic [CodeW-1:0] byte_zero;
		logic [CodeW-1:0] byte_one;
		logic [CodeW-1:0] byte_two;
		logic [CodeW-1:0] byte_three;
		logic             frame_end;
	} res_t;

	// Pipeline control: one shared advance, valid bit per stage
	typedef struct packed {
		logic                adv;
		logic [StageCnt-1:0] valid;
	} pipe_ctl_t;

	typedef logic [TabDepth-1:0][LinW-1:0] thr_tab_t;

	// Rounding thresholds in U0.32 linear light; entry 0 is zero.
	// Linear segment: ceil((2k-1)*5*2^32/32946).
	// Power segment: least V with V^5 * 10761^12 >= (40k+541)^12 * 2^160.
	function automatic thr_tab_t thr_build();
		thr_tab_t     tab;
		logic [335:0] c12;
		logic [335:0] base;
		logic [335:0] rhs;
		logic [335:0] t1;
		logic [335:0] t2;
		logic [335:0] t4;
		logic [335:0] lhs;
		logic [63:0]  num;
		logic [LinW-1:0] lo;
		logic [LinW-1:0] hi;
		logic [LinW-1:0] mid;
		tab = '0;
		c12 = 336'd1;
		for (int i = 0; i < 12; i++) begin
			c12 = c12 * 336'd10761;
		end
		for (int k = 1; k < TabDepth; k++) begin
			if (k <= LinLastCode) begin
				num = (64'(2 * k - 1) * 64'd5) << 32;
				tab[k] = LinW'((num + 64'd32945) / 64'd32946);
			end else begin
				base = 336'd1;
				for (int i = 0; i < 12; i++) begin
					base = base * 336'(40 * k + 541);
				end
				rhs = base << 160;
				lo = '0;
				hi = 33'h0_FFFF_FFFF;
				while (lo < hi) begin
					mid = lo + ((hi - lo) >> 1);
					t1 = 336'(mid);
					t2 = t1 * t1;
					t4 = t2 * t2;
					lhs = t4 * t1 * c12;
					if (lhs >= rhs) begin
						hi = mid;
					end else begin
						lo = mid + 33'd1;
					end
				end
				tab[k] = lo;
			end
		end
		return tab;
	endfunction

	localparam thr_tab_t ThrTable = thr_build();

endpackage

>>> rtl/hdrtm_lin.sv
`timescale 1ns / 1ps

// Half decode, white scaling and clip to 1.0 in U1.32 (stages 1 and 2)
module hdrtm_lin (
	input  logic                          clk,
	input  logic                          adv,
	input  logic [hdrtm_pkg::HalfW-1:0]   half,
	input  logic [hdrtm_pkg::ScaleW-1:0]  white_scale,
	output logic [hdrtm_pkg::LinW-1:0]    lin_s2
);

	logic       sign;
	logic [4:0] expo;
	logic [9:0] man;
	logic [10:0] sig;
	logic [4:0] ex_eff;
	logic       kill;
	logic       inf;
	logic [hdrtm_pkg::ProdW-1:0] prod;

	logic [hdrtm_pkg::ProdW-1:0] prod_s1;
	logic [4:0] ex_s1;
	logic       kill_s1;
	logic       inf_s1;

	logic [67:0] wide;
	logic [51:0] scaled;
	logic        over;

	// Stage 1: unpack and multiply by the white scale
	assign sign   = half[15];
	assign expo   = half[14:10];
	assign man    = half[9:0];
	assign sig    = (expo == '0) ? {1'b0, man} : {1'b1, man};
	assign ex_eff = (expo == '0) ? 5'd1 : expo;
	// negatives, NaN, and infinity times zero all map to zero
	assign kill   = sign || ((expo == hdrtm_pkg::ExpMax) && ((man != '0) || (white_scale == '0)));
	assign inf    = (expo == hdrtm_pkg::ExpMax);
	assign prod   = hdrtm_pkg::ProdW'(sig) * hdrtm_pkg::ProdW'(white_scale);

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1 <= prod;
			ex_s1   <= ex_eff;
			kill_s1 <= kill;
			inf_s1  <= inf;
		end
	end

	// Stage 2: value = prod * 2^(e-9), floor, saturate above 1.0
	assign wide   = 68'({prod_s1, 8'b0}) << (ex_s1 - 5'd1);
	assign scaled = wide[67:16];
	assign over   = (scaled[51:33] != '0) || (scaled[32] && (scaled[31:0] != '0));

	always_ff @(posedge clk) begin
		if (adv) begin
			if (kill_s1) begin
				lin_s2 <= '0;
			end else if (inf_s1 || over) begin
				lin_s2 <= hdrtm_pkg::OneLin;
			end else begin
				lin_s2 <= scaled[hdrtm_pkg::LinW-1:0];
			end
		end
	end

endmodule

>>> rtl/hdrtm_search.sv
`timescale 1ns / 1ps

// Binary search over the threshold table, one code bit per stage, MSB first
module hdrtm_search (
	input  logic                          clk,
	input  logic                          adv,
	input  logic [hdrtm_pkg::LinW-1:0]    lin,
	output logic [hdrtm_pkg::CodeW-1:0]   code
);

	localparam int Steps = hdrtm_pkg::SrchSteps;

	// index j holds the register of search stage j (pipeline stage j+3)
	logic [hdrtm_pkg::LinW-1:0]  lin_s  [Steps-1];
	logic [hdrtm_pkg::CodeW-1:0] code_s [Steps];

	logic [hdrtm_pkg::LinW-1:0]  lin_in  [Steps];
	logic [hdrtm_pkg::CodeW-1:0] code_in [Steps];
	logic [hdrtm_pkg::CodeW-1:0] trial   [Steps];
	logic                        hit     [Steps];

	for (genvar j = 0; j < Steps; j++) begin : g_step
		if (j == 0) begin : g_first
			assign lin_in[j]  = lin;
			assign code_in[j] = '0;
		end else begin : g_next
			assign lin_in[j]  = lin_s[j-1];
			assign code_in[j] = code_s[j-1];
		end

		// try setting this bit; keep it if the value reaches that threshold
		assign trial[j] = code_in[j] | hdrtm_pkg::CodeW'(1 << (hdrtm_pkg::CodeW - 1 - j));
		assign hit[j]   = (lin_in[j] >= hdrtm_pkg::ThrTable[trial[j]]);

		always_ff @(posedge clk) begin
			if (adv) begin
				code_s[j] <= hit[j] ? trial[j] : code_in[j];
			end
		end

		if (j < Steps - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (adv) begin
					lin_s[j] <= lin_in[j];
				end
			end
		end
	end

	assign code = code_s[Steps-1];

endmodule

>>> rtl/hdrtm_ctl.sv
`timescale 1ns / 1ps

// Stage valid bits and the shared pipeline advance
module hdrtm_ctl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pix_valid,
	input  logic                  sink_ready,
	output logic                  pix_ready,
	output hdrtm_pkg::pipe_ctl_t  ctl
);

	localparam int Last = hdrtm_pkg::StageCnt - 1;

	logic [hdrtm_pkg::StageCnt-1:0] valid_q;
	logic                           adv;

	// move when the output side takes the tail, or the tail is a bubble
	assign adv       = sink_ready || !valid_q[Last];
	assign pix_ready = adv;

	assign ctl.adv   = adv;
	assign ctl.valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (adv) begin
			valid_q <= {valid_q[Last-1:0], pix_valid};
		end
	end

endmodule

>>> rtl/hdrtm_skid.sv
`timescale 1ns / 1ps

// Two-entry output buffer; ready toward the pipeline is registered
module hdrtm_skid (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  hdrtm_pkg::res_t  in_data,
	output logic             res_valid,
	input  logic             res_ready,
	output hdrtm_pkg::res_t  res
);

	logic            out_valid_q;
	hdrtm_pkg::res_t out_data_q;
	logic            spare_valid_q;
	hdrtm_pkg::res_t spare_data_q;
	logic            push;
	logic            pop;

	assign in_ready  = !spare_valid_q;
	assign res_valid = out_valid_q;
	assign res       = out_data_q;
	assign push      = in_valid && in_ready;
	assign pop       = out_valid_q && res_ready;

	// Valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q   <= 1'b0;
			spare_valid_q <= 1'b0;
		end else if (spare_valid_q) begin
			if (pop) begin
				spare_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (out_valid_q && !pop) begin
				spare_valid_q <= 1'b1;
			end
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (spare_valid_q) begin
			if (pop) begin
				out_data_q <= spare_data_q;
			end
		end else if (push) begin
			if (out_valid_q && !pop) begin
				spare_data_q <= in_data;
			end else begin
				out_data_q <= in_data;
			end
		end
	end

endmodule

>>> rtl/hdr_half_pixel_to_srgb8_tonemap_top.sv
// Throughput: one pixel per cycle unless the output buffer is full, which stalls
// the pipeline; ten pipeline stages (two for decode and scaling, eight for the
// one-bit-per-stage threshold search) plus an output buffer.
// Reset: stage valid bits and output buffer clear; white_scale returns to 1.0
// (65536) and byte_order to RGBA.
`timescale 1ns / 1ps

module hdr_half_pixel_to_srgb8_tonemap_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             pix_valid,
	output logic                             pix_ready,
	input  hdrtm_pkg::pix_t                  pix,
	output logic                             res_valid,
	input  logic                             res_ready,
	output hdrtm_pkg::res_t                  res,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [hdrtm_pkg::CfgIdxW-1:0]    cfg_index,
	input  logic [hdrtm_pkg::ScaleW-1:0]     cfg_data
);

	localparam int Last = hdrtm_pkg::StageCnt - 1;

	logic [hdrtm_pkg::ScaleW-1:0] white_scale_q;
	logic                         byte_order_q;

	hdrtm_pkg::pipe_ctl_t         pipe;
	logic                         skid_ready;
	hdrtm_pkg::res_t              skid_in;

	logic [hdrtm_pkg::HalfW-1:0]  half_in [hdrtm_pkg::ChanCnt];
	logic [hdrtm_pkg::LinW-1:0]   lin     [hdrtm_pkg::ChanCnt];
	logic [hdrtm_pkg::CodeW-1:0]  code    [hdrtm_pkg::ChanCnt];
	logic                         last_s  [hdrtm_pkg::StageCnt];

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			white_scale_q <= hdrtm_pkg::WhiteScaleRst;
			byte_order_q  <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				hdrtm_pkg::CfgWhiteScale: white_scale_q <= cfg_data;
				hdrtm_pkg::CfgByteOrder:  byte_order_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Pipeline control
	hdrtm_ctl u_ctl (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix_valid  (pix_valid),
		.sink_ready (skid_ready),
		.pix_ready  (pix_ready),
		.ctl        (pipe)
	);

	// Per-channel datapath: red, green, blue
	assign half_in[0] = pix.red_half;
	assign half_in[1] = pix.green_half;
	assign half_in[2] = pix.blue_half;

	for (genvar c = 0; c < hdrtm_pkg::ChanCnt; c++) begin : g_chan
		hdrtm_lin u_lin (
			.clk         (clk),
			.adv         (pipe.adv),
			.half        (half_in[c]),
			.white_scale (white_scale_q),
			.lin_s2      (lin[c])
		);

		hdrtm_search u_search (
			.clk  (clk),
			.adv  (pipe.adv),
			.lin  (lin[c]),
			.code (code[c])
		);
	end

	// Frame marker follows the data through every stage
	always_ff @(posedge clk) begin
		if (pipe.adv) begin
			last_s[0] <= pix.last_pixel;
			for (int i = 1; i < hdrtm_pkg::StageCnt; i++) begin
				last_s[i] <= last_s[i-1];
			end
		end
	end

	// Byte ordering
	assign skid_in.byte_zero  = byte_order_q ? code[2] : code[0];
	assign skid_in.byte_one   = code[1];
	assign skid_in.byte_two   = byte_order_q ? code[0] : code[2];
	assign skid_in.byte_three = hdrtm_pkg::AlphaCode;
	assign skid_in.frame_end  = last_s[Last];

	hdrtm_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pipe.valid[Last]),
		.in_ready  (skid_ready),
		.in_data   (skid_in),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// Checks
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix_ready |=> pipe.valid[0])
		else $error("accepted pixel did not enter stage 1");

	a_tail_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pipe.valid[Last] && !skid_ready |=> pipe.valid[Last])
		else $error("pipeline tail dropped while output buffer full");

	a_lin_range: assert property (@(posedge clk) disable iff (!arst_n)
		pipe.valid[1] |-> (lin[0] <= hdrtm_pkg::OneLin) && (lin[1] <= hdrtm_pkg::OneLin)
			&& (lin[2] <= hdrtm_pkg::OneLin))
		else $error("linear value above 1.0 after clipping");

	a_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.byte_three == hdrtm_pkg::AlphaCode)
		else $error("alpha byte not opaque");

endmodule

>>> tb/srgb8_pixel_checker.sv
`timescale 1ns / 1ps

module srgb8_pixel_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          pix_valid,
	input  logic                          pix_ready,
	input  hdrtm_pkg::pix_t               pix,
	input  logic                          res_valid,
	input  logic                          res_ready,
	input  hdrtm_pkg::res_t               res,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [hdrtm_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [hdrtm_pkg::ScaleW-1:0]  cfg_data,
	output int                            fail_cnt,
	output int                            pending
);
	import hdrtm_pkg::*;

	localparam logic [63:0]      LinOne      = 64'h1_0000_0000;
	localparam logic [CodeW-1:0] AlphaOpaque = 8'hFF;

	// U0.32 linear value at which each sRGB code begins
	logic [63:0]       code_edge [1:255];
	logic [ScaleW-1:0] scale_q;
	logic              order_q;
	res_t              encoded_px_q [$];
	res_t              want;
	int                err_total = 0;
	int                depth = 0;

	assign fail_cnt = err_total;
	assign pending  = depth;

	// exact power-segment test: v^5 * 10761^12 >= (40k+541)^12 * 2^160
	function automatic bit above_pow_edge(logic [63:0] v, int k);
		logic [383:0] lhs;
		logic [383:0] rhs;
		lhs = 384'(v);
		rhs = 384'd1;
		for (int i = 0; i < 4; i++) begin
			lhs = lhs * 384'(v);
		end
		for (int i = 0; i < 12; i++) begin
			lhs = lhs * 384'd10761;
			rhs = rhs * 384'(40 * k + 541);
		end
		return lhs >= (rhs << 160);
	endfunction

	initial begin : build_edges
		real         x;
		logic [63:0] g;
		for (int k = 1; k <= 255; k++) begin
			if (k <= 10) begin
				// linear segment: ceil((2k-1)*5*2^32/32946)
				g = 64'(2 * k - 1) * 64'd5;
				code_edge[k] = ((g << 32) + 64'd32945) / 64'd32946;
			end else begin
				// float estimate, then walk to the least exact crossing
				x = ((k - 0.5) / 255.0 + 0.055) / 1.055;
				g = 64'(longint'((x ** 2.4) * 4294967296.0));
				while (g > 0 && above_pow_edge(g - 64'd1, k)) begin
					g = g - 64'd1;
				end
				while (!above_pow_edge(g, k)) begin
					g = g + 64'd1;
				end
				code_edge[k] = g;
			end
		end
	end

	// one half channel to its sRGB code under the current scale
	function automatic logic [CodeW-1:0] channel_code(logic [HalfW-1:0] h);
		logic [4:0]  ex;
		logic [10:0] sig;
		logic [63:0] lin;
		int          sh;
		int          n;
		ex = h[14:10];
		if (h[15]) begin
			return '0;
		end
		if (ex == ExpMax) begin
			// NaN, or infinity times a zero scale
			if (h[9:0] != '0 || scale_q == '0) begin
				return '0;
			end
			lin = LinOne;
		end else begin
			sig = (ex == 5'd0) ? {1'b0, h[9:0]} : {1'b1, h[9:0]};
			sh  = (ex == 5'd0) ? 1 : int'(ex);
			lin = 64'(sig) * 64'(scale_q);
			if (sh >= 9) begin
				lin = lin << (sh - 9);
			end else begin
				lin = lin >> (9 - sh);
			end
			if (lin > LinOne) begin
				lin = LinOne;
			end
		end
		n = 0;
		for (int k = 1; k <= 255; k++) begin
			if (lin >= code_edge[k]) begin
				n++;
			end
		end
		return CodeW'(n);
	endfunction

	function automatic res_t encode_pixel(pix_t p);
		res_t             e;
		logic [CodeW-1:0] r;
		logic [CodeW-1:0] g;
		logic [CodeW-1:0] b;
		r = channel_code(p.red_half);
		g = channel_code(p.green_half);
		b = channel_code(p.blue_half);
		e.byte_zero  = order_q ? b : r;
		e.byte_one   = g;
		e.byte_two   = order_q ? r : b;
		e.byte_three = AlphaOpaque;
		e.frame_end  = p.last_pixel;
		return e;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q = WhiteScaleRst;
			order_q = 1'b0;
			encoded_px_q.delete();
			depth = 0;
		end else begin
			// result transaction: compare with the oldest prediction
			if (res_valid && res_ready) begin
				if (encoded_px_q.size() == 0) begin
					$error("result transaction with no pixel outstanding");
					err_total++;
				end else begin
					want = encoded_px_q.pop_front();
					if (res.byte_zero !== want.byte_zero) begin
						$error("byte_zero: expected %0d, actual %0d",
							want.byte_zero, res.byte_zero);
						err_total++;
					end
					if (res.byte_one !== want.byte_one) begin
						$error("byte_one: expected %0d, actual %0d",
							want.byte_one, res.byte_one);
						err_total++;
					end
					if (res.byte_two !== want.byte_two) begin
						$error("byte_two: expected %0d, actual %0d",
							want.byte_two, res.byte_two);
						err_total++;
					end
					if (res.byte_three !== want.byte_three) begin
						$error("byte_three: expected %0d, actual %0d",
							want.byte_three, res.byte_three);
						err_total++;
					end
					if (res.frame_end !== want.frame_end) begin
						$error("frame_end: expected %0d, actual %0d",
							want.frame_end, res.frame_end);
						err_total++;
					end
				end
			end
			// pixel transaction: predict with the settings in force now
			if (pix_valid && pix_ready) begin
				encoded_px_q.push_back(encode_pixel(pix));
			end
			// register write; spare indexes are dropped
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CfgWhiteScale: scale_q = cfg_data;
					CfgByteOrder:  order_q = cfg_data[0];
					default: ;
				endcase
			end
			depth = encoded_px_q.size();
		end
	end

endmodule

>>> tb/hdr_half_pixel_to_srgb8_tonemap_top_tb.sv
`timescale 1ns / 1ps

module hdr_half_pixel_to_srgb8_tonemap_top_tb;
	import hdrtm_pkg::*;

	localparam logic [CfgIdxW-1:0] CfgSpareLo = CfgIdxW'(2);
	localparam logic [CfgIdxW-1:0] CfgSpareHi = CfgIdxW'(3);
	localparam logic [ScaleW-1:0]  ScaleMax   = 20'hFFFFF;
	localparam int                 IdleLimit  = 4000;
	localparam int                 HoldCycles = 300;
	localparam int                 DrainWait  = 30;
	localparam int                 PhaseCnt   = 10;
	localparam int                 PhaseItems = 125;
	localparam int                 FillItems  = 80;

	logic                clk;
	logic                arst_n;
	logic                pix_valid;
	logic                pix_ready;
	pix_t                pix;
	logic                res_valid;
	logic                res_ready;
	res_t                res;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [ScaleW-1:0]   cfg_data;
	int                  fail_cnt;
	int                  pending;

	bit                  idle_on = 1'b1;
	int                  long_hold = 0;
	int                  px_sent = 0;
	int                  cfg_writes = 0;
	int                  idle_run = 0;

	hdr_half_pixel_to_srgb8_tonemap_top uut (.*);

	srgb8_pixel_checker chk (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// no transaction on any channel for too long ends the run
	always @(posedge clk) begin
		if ((pix_valid && pix_ready) || (res_valid && res_ready) || (cfg_valid && cfg_ready)) begin
			idle_run <= 0;
		end else begin
			idle_run <= idle_run + 1;
		end
		if (idle_run >= IdleLimit) begin
			$display("hdr_half_pixel_to_srgb8_tonemap_top_tb: done, errors");
			$finish;
		end
	end

	// output side: random stalls, or one long hold-off when asked
	initial begin : drain_side
		int stall;
		res_ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (long_hold > 0) begin
				stall = long_hold;
				long_hold = 0;
			end else begin
				stall = idle_on ? $urandom_range(0, 5) : 0;
			end
			if (stall > 0) begin
				res_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ready <= 1'b1;
			@(posedge clk);
			while (!res_valid) @(posedge clk);
		end
	end

	function automatic logic [HalfW-1:0] draw_half();
		logic [HalfW-1:0] h;
		h = HalfW'($urandom);
		case ($urandom_range(0, 9))
			0, 1, 2: ;
			// positive, below 4.0: the useful range
			3, 4, 5, 6, 7: h[15:10] = {1'b0, 5'($urandom_range(0, 16))};
			// infinity or NaN, either sign
			8: begin
				h[14:10] = ExpMax;
				if ($urandom_range(0, 1) == 0) begin
					h[9:0] = '0;
				end
			end
			// tiny positive values, subnormals and the linear segment
			default: h[15:13] = 3'b000;
		endcase
		return h;
	endfunction

	function automatic pix_t draw_pixel();
		pix_t p;
		p.red_half   = draw_half();
		p.green_half = draw_half();
		p.blue_half  = draw_half();
		p.last_pixel = ($urandom_range(0, 15) == 0);
		return p;
	endfunction

	function automatic pix_t make_pixel(logic [HalfW-1:0] r, logic [HalfW-1:0] g,
		logic [HalfW-1:0] b, logic last);
		pix_t p;
		p.red_half   = r;
		p.green_half = g;
		p.blue_half  = b;
		p.last_pixel = last;
		return p;
	endfunction

	// called at a rising edge; returns at the edge that takes the transaction
	task automatic send_px(input pix_t p);
		int gap;
		gap = idle_on ? $urandom_range(0, 5) : 0;
		if (gap > 0) begin
			pix_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix       <= p;
		pix_valid <= 1'b1;
		@(posedge clk);
		while (!pix_ready) @(posedge clk);
		px_sent++;
	endtask

	// register write once every outstanding pixel has come back
	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ScaleW-1:0] data);
		pix_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
		cfg_index <= idx;
		cfg_data  <= data;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		cfg_writes++;
	endtask

	initial begin : stimulus
		logic [HalfW-1:0]  probe [14];
		logic [ScaleW-1:0] ws;
		logic [ScaleW-1:0] od;
		arst_n    <= 1'b0;
		pix_valid <= 1'b0;
		pix       <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		// zeros, subnormal edges, the linear/power knee, around 1.0, max, inf, NaN
		probe = '{16'h0000, 16'h8000, 16'h0001, 16'h03FF, 16'h0400, 16'h1A69, 16'h2E66,
			16'h3BFF, 16'h3C00, 16'h3C01, 16'h7BFF, 16'h7C00, 16'hFC00, 16'h7E00};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: each probe value lands on every channel
		for (int i = 0; i < 14; i++) begin
			send_px(make_pixel(probe[i], probe[(i + 5) % 14], probe[(i + 9) % 14], i[0]));
		end

		// zero scale: finite values and infinity all give zero
		write_reg(CfgWhiteScale, '0);
		send_px(make_pixel(16'h7C00, 16'h3C00, 16'h7BFF, 1'b1));
		send_px(make_pixel(16'h0001, 16'h7C01, 16'hFFFF, 1'b0));

		// largest scale, BGRA selected through a wide data word
		write_reg(CfgWhiteScale, ScaleMax);
		write_reg(CfgByteOrder, ScaleMax);
		send_px(make_pixel(16'h0001, 16'h03FF, 16'h0400, 1'b0));
		send_px(make_pixel(16'h2000, 16'h3C00, 16'h7C00, 1'b1));

		// random phases, each under its own settings
		for (int ph = 0; ph < PhaseCnt; ph++) begin
			case (ph)
				0: begin ws = WhiteScaleRst; od = 20'h0;      end
				1: begin ws = ScaleMax;      od = 20'h1;      end
				2: begin ws = '0;            od = 20'hFFFFE;  end
				3: begin ws = 20'd1;         od = 20'h1;      end
				4: begin ws = 20'd16384;     od = ScaleW'($urandom); end
				5: begin ws = 20'd65535;     od = 20'h0;      end
				default: begin
					ws = ScaleW'($urandom_range(0, ScaleMax)) >> $urandom_range(0, 4);
					od = ScaleW'($urandom);
				end
			endcase
			write_reg(CfgWhiteScale, ws);
			write_reg(CfgByteOrder, od);
			if (ph == 3) begin
				// spare indexes must leave both registers alone
				write_reg(CfgSpareLo, ScaleW'($urandom));
				write_reg(CfgSpareHi, ScaleMax);
			end
			for (int i = 0; i < PhaseItems; i++) begin
				if (i % 40 == 0) begin
					idle_on = ($urandom_range(0, 3) != 0);
				end
				send_px(draw_pixel());
			end
		end

		// back-to-back pixels against a long output hold-off
		write_reg(CfgWhiteScale, ScaleW'($urandom_range(0, 20'h1FFFF)));
		write_reg(CfgByteOrder, ScaleW'($urandom));
		idle_on   = 1'b0;
		long_hold = HoldCycles;
		for (int i = 0; i < FillItems; i++) begin
			send_px(draw_pixel());
		end
		pix_valid <= 1'b0;
		idle_on = 1'b1;

		// drain, then give stray results time to show up
		do @(negedge clk); while (pending != 0);
		repeat (DrainWait) @(posedge clk);

		$display("tonemap run: %0d pixels over %0d register writes, scales zero to max, RGBA and BGRA",
			px_sent, cfg_writes);
		$display("tonemap run: signs, NaN, infinity, subnormals, one %0d-cycle output hold-off",
			HoldCycles);
		if (fail_cnt == 0 && pending == 0) begin
			$display("hdr_half_pixel_to_srgb8_tonemap_top_tb: done, clean");
		end else begin
			$display("hdr_half_pixel_to_srgb8_tonemap_top_tb: done, errors");
		end
		$finish;
	end

endmodule

>>> filelist.f
rtl/hdrtm_pkg.sv
rtl/hdrtm_lin.sv
rtl/hdrtm_search.sv
rtl/hdrtm_ctl.sv
rtl/hdrtm_skid.sv
rtl/hdr_half_pixel_to_srgb8_tonemap_top.sv
tb/srgb8_pixel_checker.sv
tb/hdr_half_pixel_to_srgb8_tonemap_top_tb.sv
